[design/gha_pkg.sv]
// ----------------------------------------------------------------------------
// gha_pkg: shared types and constants of the generational handle allocator
// Pool size, slot and handle widths, mode codes and the retire limit.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int SLOTS  = 256;
  localparam int SLOT_W = $clog2(SLOTS);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [SLOT_W:0]   count_t;
  typedef logic [31:0]       handle_t;
  typedef logic [2:0]        mode_t;
  typedef logic [15:0]       slot_in_t;

  localparam mode_t MODE_ALLOC   = 3'd0;
  localparam mode_t MODE_RELEASE = 3'd1;
  localparam mode_t MODE_TEST_H  = 3'd2;
  localparam mode_t MODE_TEST_S  = 3'd3;
  localparam mode_t MODE_STEP_F  = 3'd4;
  localparam mode_t MODE_STEP_B  = 3'd5;
  localparam mode_t MODE_PEEK    = 3'd6;

  // Released handles at or above this value retire their slot
  localparam handle_t RETIRE_LIM = 32'(64'hFFFF_FFFF - 64'(2 * SLOTS) - 64'd2);
  // Generation step applied to a slot on release
  localparam handle_t GEN_STEP   = 32'(SLOTS + 1);

  localparam slot_t  SLOT_LAST   = SLOT_W'(SLOTS - 1);
  localparam count_t COUNT_FULL  = (SLOT_W + 1)'(SLOTS);

endpackage

[design/generational_handle_allocator.sv]
// ----------------------------------------------------------------------------
// generational_handle_allocator: pool of generational 32-bit handles
// Free and used slots form circular doubly linked lists in shared link
// memories; each slot memory entry holds the slot's current generation.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive in_mode, in_handle and in_slot and raise start;
//   the command beat is taken at a clock edge where start is high and busy
//   is low. Modes: allocate, release, test handle, test slot, step the used
//   cursor forward or back, peek the next slot to allocate.
//   Result channel: one result beat per command, on out_ok, out_handle_out
//   and out_slot_out for exactly one cycle while out_valid is high. The
//   receiver cannot stall; it must take the beat in that cycle.
//   Path from the accept edge: tests, steps, peeks, failed commands and a
//   release that retires its slot give their result from the execute
//   state; a link into an empty list adds the first link-in state; other
//   allocations and releases add both link-in states. busy drops in the
//   cycle of the result beat; no new command is taken while one is in
//   flight. The link-in states come from the single write port of each
//   link memory: unlink, then two link-in writes.
//   Reset: a clearing pass over all 256 slots rebuilds the link and
//   generation memories; busy stays high during it and no command is taken.
// ----------------------------------------------------------------------------
module generational_handle_allocator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  gha_pkg::mode_t    in_mode,
  input  gha_pkg::handle_t  in_handle,
  input  gha_pkg::slot_in_t in_slot,
  output logic              out_valid,
  output logic              out_ok,
  output gha_pkg::handle_t  out_handle_out,
  output logic [7:0]        out_slot_out
);
  import gha_pkg::*;

  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_LINK1 = 5'b01000,
    ST_LINK2 = 5'b10000
  } state_t;

  // Slot memories
  slot_t   nl_mem [SLOTS];
  slot_t   pl_mem [SLOTS];
  handle_t sh_mem [SLOTS];

  slot_t   nl_q, pl_q;
  handle_t sh_q;
  slot_t   rd_addr, pl_rd_addr;
  logic    nl_we, pl_we, sh_we;
  slot_t   nl_wa, pl_wa, sh_wa;
  slot_t   nl_wd, pl_wd;
  handle_t sh_wd;

  // Control and command registers
  state_t  state_r, state_nxt;
  slot_t   init_cnt_r, init_cnt_nxt;
  slot_t   free_head_r, free_head_nxt;
  slot_t   cursor_r, cursor_nxt;
  count_t  used_cnt_r, used_cnt_nxt;
  count_t  free_cnt_r, free_cnt_nxt;
  mode_t   mode_r;
  handle_t h_r;
  slot_t   s_r;
  logic    sl_ok_r;
  slot_t   anchor_r, anchor_nxt;
  slot_t   pa_r, pa_nxt;
  logic    empty_r, empty_nxt;
  logic    to_used_r, to_used_nxt;
  handle_t hout_r, hout_nxt;

  // Result registers
  logic    out_valid_r;
  logic    out_ok_r;
  handle_t out_h_r;
  slot_t   out_s_r;
  logic    res_ld;
  logic    res_ok;
  handle_t res_h;
  slot_t   res_s;

  logic    accept;
  slot_t   acc_addr;
  logic    rel_match;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Pick the slot a command looks at
  always_comb begin
    unique case (in_mode)
      MODE_ALLOC, MODE_PEEK:    acc_addr = free_head_r;
      MODE_RELEASE, MODE_TEST_H: acc_addr = in_handle[SLOT_W-1:0];
      MODE_TEST_S:              acc_addr = in_slot[SLOT_W-1:0];
      MODE_STEP_F, MODE_STEP_B: acc_addr = cursor_r;
      default:                  acc_addr = '0;
    endcase
  end

  assign rd_addr    = acc_addr;
  assign pl_rd_addr = (state_r == ST_EXEC) ?
                      ((mode_r == MODE_ALLOC) ? cursor_r : free_head_r) : acc_addr;

  assign rel_match = (sh_q == h_r) && (used_cnt_r != '0);

  // Sequence clearing, unlink and link-in steps
  always_comb begin
    state_nxt     = state_r;
    init_cnt_nxt  = init_cnt_r;
    free_head_nxt = free_head_r;
    cursor_nxt    = cursor_r;
    used_cnt_nxt  = used_cnt_r;
    free_cnt_nxt  = free_cnt_r;
    anchor_nxt    = anchor_r;
    pa_nxt        = pa_r;
    empty_nxt     = empty_r;
    to_used_nxt   = to_used_r;
    hout_nxt      = hout_r;
    nl_we = 1'b0; nl_wa = '0; nl_wd = '0;
    pl_we = 1'b0; pl_wa = '0; pl_wd = '0;
    sh_we = 1'b0; sh_wa = '0; sh_wd = '0;
    res_ld = 1'b0; res_ok = 1'b0; res_h = '0; res_s = '0;

    unique case (state_r)
      ST_INIT: begin
        nl_we = 1'b1; nl_wa = init_cnt_r;
        nl_wd = (init_cnt_r == SLOT_LAST) ? '0 : init_cnt_r + 1'b1;
        pl_we = 1'b1; pl_wa = init_cnt_r;
        pl_wd = (init_cnt_r == '0) ? SLOT_LAST : init_cnt_r - 1'b1;
        sh_we = 1'b1; sh_wa = init_cnt_r;
        sh_wd = 32'(init_cnt_r) + 32'd1;
        init_cnt_nxt = init_cnt_r + 1'b1;
        if (init_cnt_r == SLOT_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_ld    = 1'b1;
        state_nxt = ST_IDLE;
        unique case (mode_r)
          MODE_ALLOC: begin
            if (free_cnt_r != '0) begin
              // Unlink head of free list, drop generation by one
              res_ld = 1'b0;
              nl_we = 1'b1; nl_wa = pl_q; nl_wd = nl_q;
              pl_we = 1'b1; pl_wa = nl_q; pl_wd = pl_q;
              sh_we = 1'b1; sh_wa = s_r;  sh_wd = sh_q - 32'd1;
              free_head_nxt = nl_q;
              free_cnt_nxt  = free_cnt_r - 1'b1;
              used_cnt_nxt  = used_cnt_r + 1'b1;
              hout_nxt      = sh_q - 32'd1;
              anchor_nxt    = cursor_r;
              empty_nxt     = (used_cnt_r == '0);
              to_used_nxt   = 1'b1;
              state_nxt     = ST_LINK1;
            end
          end
          MODE_RELEASE: begin
            res_s = s_r;
            if (rel_match) begin
              // Unlink from used list, advance generation
              nl_we = 1'b1; nl_wa = pl_q; nl_wd = nl_q;
              pl_we = 1'b1; pl_wa = nl_q; pl_wd = pl_q;
              sh_we = 1'b1; sh_wa = s_r;  sh_wd = sh_q + GEN_STEP;
              if (cursor_r == s_r) begin
                cursor_nxt = nl_q;
              end
              used_cnt_nxt = used_cnt_r - 1'b1;
              hout_nxt     = h_r;
              if (h_r < RETIRE_LIM) begin
                res_ld       = 1'b0;
                free_cnt_nxt = free_cnt_r + 1'b1;
                anchor_nxt   = free_head_r;
                empty_nxt    = (free_cnt_r == '0);
                to_used_nxt  = 1'b0;
                state_nxt    = ST_LINK1;
              end else begin
                res_ok = 1'b1;
                res_h  = h_r;
              end
            end
          end
          MODE_TEST_H: begin
            res_ok = (sh_q == h_r);
            res_h  = sh_q;
            res_s  = s_r;
          end
          MODE_TEST_S: begin
            if (sl_ok_r) begin
              res_ok = (sh_q[SLOT_W-1:0] == s_r);
              res_h  = sh_q;
              res_s  = s_r;
            end
          end
          MODE_STEP_F, MODE_STEP_B: begin
            if (used_cnt_r != '0) begin
              res_ok     = 1'b1;
              res_h      = sh_q;
              res_s      = s_r;
              cursor_nxt = (mode_r == MODE_STEP_F) ? nl_q : pl_q;
            end
          end
          MODE_PEEK: begin
            if (free_cnt_r != '0) begin
              res_ok = 1'b1;
              res_s  = s_r;
            end
          end
          default: begin
            res_ok = 1'b0;
          end
        endcase
      end

      ST_LINK1: begin
        pa_nxt = pl_q;
        if (empty_r) begin
          // Slot becomes a one-entry list and its anchor
          nl_we = 1'b1; nl_wa = s_r; nl_wd = s_r;
          pl_we = 1'b1; pl_wa = s_r; pl_wd = s_r;
          if (to_used_r) begin
            cursor_nxt = s_r;
          end else begin
            free_head_nxt = s_r;
          end
          res_ld = 1'b1; res_ok = 1'b1; res_h = hout_r; res_s = s_r;
          state_nxt = ST_IDLE;
        end else begin
          nl_we = 1'b1; nl_wa = s_r; nl_wd = anchor_r;
          pl_we = 1'b1; pl_wa = s_r; pl_wd = pl_q;
          state_nxt = ST_LINK2;
        end
      end

      ST_LINK2: begin
        // Close the ring around the inserted slot
        pl_we = 1'b1; pl_wa = anchor_r; pl_wd = s_r;
        nl_we = 1'b1; nl_wa = pa_r;     nl_wd = s_r;
        res_ld = 1'b1; res_ok = 1'b1; res_h = hout_r; res_s = s_r;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  // Write and read the slot memories
  always_ff @(posedge clk) begin
    if (nl_we) begin
      nl_mem[nl_wa] <= nl_wd;
    end
    if (pl_we) begin
      pl_mem[pl_wa] <= pl_wd;
    end
    if (sh_we) begin
      sh_mem[sh_wa] <= sh_wd;
    end
    nl_q <= nl_mem[rd_addr];
    pl_q <= pl_mem[pl_rd_addr];
    sh_q <= sh_mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_cnt_r  <= '0;
      free_head_r <= '0;
      cursor_r    <= '0;
      used_cnt_r  <= '0;
      free_cnt_r  <= COUNT_FULL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      free_head_r <= free_head_nxt;
      cursor_r    <= cursor_nxt;
      used_cnt_r  <= used_cnt_nxt;
      free_cnt_r  <= free_cnt_nxt;
      out_valid_r <= res_ld;
    end
  end

  // Command capture, link-in context and result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      h_r     <= in_handle;
      s_r     <= acc_addr;
      sl_ok_r <= (32'(in_slot) < 32'(SLOTS));
    end
    anchor_r  <= anchor_nxt;
    pa_r      <= pa_nxt;
    empty_r   <= empty_nxt;
    to_used_r <= to_used_nxt;
    hout_r    <= hout_nxt;
    if (res_ld) begin
      out_ok_r <= res_ok;
      out_h_r  <= res_h;
      out_s_r  <= res_s;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_handle_out = out_h_r;
  assign out_slot_out   = 8'(out_s_r);

endmodule

[bench/handle_pool_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_pool_checker: result checker for the generational handle allocator
// Keeps its own copy of the free and used lists and of the slot generations,
// predicts one reply per accepted command beat and compares every result
// beat, field by field, against the oldest outstanding reply.
// ----------------------------------------------------------------------------
module handle_pool_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  gha_pkg::mode_t    in_mode,
  input  gha_pkg::handle_t  in_handle,
  input  gha_pkg::slot_in_t in_slot,
  input  logic              out_valid,
  input  logic              out_ok,
  input  gha_pkg::handle_t  out_handle_out,
  input  logic [7:0]        out_slot_out,
  output int                errors,
  output int                pending
);

  localparam int SLOTS = gha_pkg::SLOTS;
  localparam int SW    = gha_pkg::SLOT_W;
  // Handles at or above this value retire their slot on release
  localparam bit [63:0] RETIRE_AT = 64'hFFFF_FFFF - 64'(2 * SLOTS) - 64'd2;

  typedef bit [SW-1:0] idx_t;

  typedef struct packed {
    bit        ok;
    bit [31:0] handle;
    bit [7:0]  slot;
  } reply_t;

  // Mirror of the pool: shared link arrays, generations, list anchors
  idx_t      next_l [SLOTS];
  idx_t      prev_l [SLOTS];
  bit [31:0] gen    [SLOTS];
  idx_t      free_head;
  idx_t      cursor;
  int        used_n;
  int        free_n;

  reply_t    expected_replies[$];

  function automatic idx_t slot_of(bit [31:0] h);
    return idx_t'(h % 32'(SLOTS));
  endfunction

  function automatic void pool_clear();
    for (int i = 0; i < SLOTS; i++) begin
      next_l[i] = idx_t'((i + 1) % SLOTS);
      prev_l[i] = idx_t'((i + SLOTS - 1) % SLOTS);
      gen[i]    = 32'(i + 1);
    end
    free_head = '0;
    cursor    = '0;
    used_n    = 0;
    free_n    = SLOTS;
  endfunction

  function automatic void unlink(idx_t s);
    idx_t p;
    idx_t n;
    p = prev_l[s];
    n = next_l[s];
    next_l[p] = n;
    prev_l[n] = p;
  endfunction

  // Splice s in just ahead of anchor a in a non-empty ring
  function automatic void insert_before(idx_t s, idx_t a);
    idx_t p;
    p = prev_l[a];
    prev_l[s] = p;
    next_l[s] = a;
    prev_l[a] = s;
    next_l[p] = s;
  endfunction

  // Apply one command to the mirror and return the reply it must produce
  function automatic reply_t pool_apply(gha_pkg::mode_t m, bit [31:0] h, bit [15:0] sl);
    reply_t r;
    idx_t   s;
    idx_t   n;
    r = '0;
    case (m)
      gha_pkg::MODE_ALLOC: begin
        if (free_n != 0) begin
          s = free_head;
          n = next_l[s];
          unlink(s);
          free_head = n;
          free_n--;
          gen[s] = gen[s] - 32'd1;
          if (used_n == 0) begin
            next_l[s] = s;
            prev_l[s] = s;
            cursor    = s;
          end else begin
            insert_before(s, cursor);
          end
          used_n++;
          r.ok     = 1'b1;
          r.handle = gen[s];
          r.slot   = 8'(s);
        end
      end
      gha_pkg::MODE_RELEASE: begin
        s = slot_of(h);
        r.slot = 8'(s);
        if (gen[s] == h && used_n != 0) begin
          n = next_l[s];
          unlink(s);
          if (cursor == s) cursor = n;
          used_n--;
          gen[s] = gen[s] + 32'(SLOTS + 1);
          // near the top of the handle space the slot drops out for good
          if (64'(h) < RETIRE_AT) begin
            if (free_n == 0) begin
              next_l[s] = s;
              prev_l[s] = s;
              free_head = s;
            end else begin
              insert_before(s, free_head);
            end
            free_n++;
          end
          r.ok     = 1'b1;
          r.handle = h;
        end
      end
      gha_pkg::MODE_TEST_H: begin
        s = slot_of(h);
        r.slot   = 8'(s);
        r.handle = gen[s];
        r.ok     = (gen[s] == h);
      end
      gha_pkg::MODE_TEST_S: begin
        if (32'(sl) < 32'(SLOTS)) begin
          s = idx_t'(sl);
          r.handle = gen[s];
          r.slot   = 8'(sl);
          r.ok     = (slot_of(gen[s]) == s);
        end
      end
      gha_pkg::MODE_STEP_F, gha_pkg::MODE_STEP_B: begin
        if (used_n != 0) begin
          s = cursor;
          r.ok     = 1'b1;
          r.handle = gen[s];
          r.slot   = 8'(s);
          cursor   = (m == gha_pkg::MODE_STEP_F) ? next_l[s] : prev_l[s];
        end
      end
      gha_pkg::MODE_PEEK: begin
        if (free_n != 0) begin
          r.ok   = 1'b1;
          r.slot = 8'(free_head);
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Compare result beats, then queue the reply of a newly accepted command
  always @(posedge clk) begin
    reply_t want;
    int     nerr;
    nerr = 0;
    if (!rst_n) begin
      pool_clear();
      expected_replies.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (out_valid) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: result beat with nothing outstanding: ok=%0b handle=%h slot=%0d",
                   $time, out_ok, out_handle_out, out_slot_out);
          nerr++;
        end else begin
          want = expected_replies.pop_front();
          if (out_ok !== want.ok) begin
            $display("%0t: out_ok mismatch, expected %0b, actual %0b",
                     $time, want.ok, out_ok);
            nerr++;
          end
          if (out_handle_out !== want.handle) begin
            $display("%0t: out_handle_out mismatch, expected %h, actual %h",
                     $time, want.handle, out_handle_out);
            nerr++;
          end
          if (out_slot_out !== want.slot) begin
            $display("%0t: out_slot_out mismatch, expected %0d, actual %0d",
                     $time, want.slot, out_slot_out);
            nerr++;
          end
        end
      end
      if (start && !busy)
        expected_replies.push_back(pool_apply(in_mode, in_handle, in_slot));
      errors  <= errors + nerr;
      pending <= expected_replies.size();
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the generational handle allocator
// Drives directed corner commands, fills the pool to exhaustion, then runs
// random allocate/release traffic with tests, steps and peeks under several
// sender idle profiles. The checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;

  import gha_pkg::*;

  localparam mode_t MODE_UNUSED = 3'd7;
  localparam int    CYCLE_LIMIT = 400000;
  localparam int    DRAIN_LIMIT = 200;
  localparam int    PHASE_ITEMS = 125;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     start     = 1'b0;
  mode_t    in_mode   = MODE_TEST_S;
  handle_t  in_handle = '0;
  slot_in_t in_slot   = '0;
  logic     busy;
  logic     out_valid;
  logic     out_ok;
  handle_t  out_handle_out;
  logic [7:0] out_slot_out;

  int errors;
  int pending;
  int cycles   = 0;
  int idle_pct = 0;
  int held     = 0;     // slots in use as seen from the command side

  handle_t live_pool[$];   // allocated handles not yet released
  handle_t stale_pool[$];  // recently released handles
  mode_t   modes_in_flight[$];
  mode_t   done_mode;

  generational_handle_allocator u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_handle      (in_handle),
    .in_slot        (in_slot),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_handle_out (out_handle_out),
    .out_slot_out   (out_slot_out)
  );

  handle_pool_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_handle      (in_handle),
    .in_slot        (in_slot),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_handle_out (out_handle_out),
    .out_slot_out   (out_slot_out),
    .errors         (errors),
    .pending        (pending)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Collect handles handed out so later releases can target live slots
  always @(posedge clk) begin
    if (rst_n && out_valid && modes_in_flight.size() != 0) begin
      done_mode = modes_in_flight.pop_front();
      if (done_mode == MODE_ALLOC && out_ok)
        live_pool.push_back(out_handle_out);
    end
  end

  // Present one command beat, hold it until taken, then idle at random
  task automatic send(mode_t m, handle_t h, slot_in_t s);
    int gap;
    gap = 0;
    in_mode   <= m;
    in_handle <= h;
    in_slot   <= s;
    start     <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    modes_in_flight.push_back(m);
    while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start     <= 1'b0;
      in_mode   <= mode_t'($urandom());
      in_handle <= $urandom();
      in_slot   <= slot_in_t'($urandom());
      repeat (gap) @(posedge clk);
    end
  endtask

  // Issue one random command; weights in percent for allocate and release
  task automatic random_command(int alloc_w, int rel_w);
    int      roll;
    int      k;
    handle_t h;
    roll = $urandom_range(99);
    if (roll < alloc_w) begin
      if (held < SLOTS) held++;
      send(MODE_ALLOC, $urandom(), slot_in_t'($urandom()));
    end else if (roll < alloc_w + rel_w) begin
      if (live_pool.size() != 0 && $urandom_range(7) != 0) begin
        k = $urandom_range(live_pool.size() - 1);
        h = live_pool[k];
        live_pool.delete(k);
        held--;
        stale_pool.push_back(h);
        if (stale_pool.size() > 64) stale_pool.delete(0);
      end else begin
        // bad releases: never a live handle
        case ($urandom_range(2))
          0: h = $urandom() | 32'h8000_0000;
          1: h = (stale_pool.size() != 0) ?
                 stale_pool[$urandom_range(stale_pool.size() - 1)] : 32'hFFFF_FFFF;
          default: h = (live_pool.size() != 0) ?
                 live_pool[$urandom_range(live_pool.size() - 1)] ^
                 (32'd1 << $urandom_range(31, 8)) : 32'hFFFF_FFFE;
        endcase
      end
      send(MODE_RELEASE, h, slot_in_t'($urandom()));
    end else begin
      roll = $urandom_range(15);
      if (roll < 5) begin
        case ($urandom_range(3))
          0: h = (live_pool.size() != 0) ?
                 live_pool[$urandom_range(live_pool.size() - 1)] : $urandom();
          1: h = (stale_pool.size() != 0) ?
                 stale_pool[$urandom_range(stale_pool.size() - 1)] : $urandom();
          2: h = $urandom();
          default: h = (live_pool.size() != 0) ?
                 live_pool[0] + 32'(SLOTS) * $urandom_range(1, 3) : $urandom();
        endcase
        send(MODE_TEST_H, h, slot_in_t'($urandom()));
      end else if (roll < 9) begin
        send(MODE_TEST_S, $urandom(), ($urandom_range(4) != 0) ?
             slot_in_t'($urandom_range(SLOTS - 1)) : slot_in_t'($urandom()));
      end else if (roll < 12) begin
        send(MODE_STEP_F, $urandom(), slot_in_t'($urandom()));
      end else if (roll < 15) begin
        send(MODE_STEP_B, $urandom(), slot_in_t'($urandom()));
      end else begin
        send(($urandom_range(3) == 0) ? MODE_UNUSED : MODE_PEEK,
             $urandom(), slot_in_t'($urandom()));
      end
    end
  endtask

  initial begin
    int pct [3];
    int aw  [3];
    int rw  [3];
    int waited;
    bit quiet;
    pct = '{85, 0, 32};
    aw  = '{10, 35, 40};
    rw  = '{70, 35, 35};
    quiet = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners: slot range edges, empty used list, stale handles
    send(MODE_TEST_S,  $urandom(), 16'd0);
    send(MODE_TEST_S,  $urandom(), slot_in_t'(SLOTS - 1));
    send(MODE_TEST_S,  $urandom(), slot_in_t'(SLOTS));
    send(MODE_TEST_S,  $urandom(), 16'hFFFF);
    send(MODE_STEP_F,  $urandom(), slot_in_t'($urandom()));
    send(MODE_STEP_B,  $urandom(), slot_in_t'($urandom()));
    send(MODE_TEST_H,  32'd0, slot_in_t'($urandom()));
    send(MODE_TEST_H,  32'hFFFF_FFFF, slot_in_t'($urandom()));
    send(MODE_RELEASE, 32'd1, slot_in_t'($urandom()));
    send(MODE_RELEASE, 32'hFFFF_FFFF, slot_in_t'($urandom()));
    send(MODE_PEEK,    $urandom(), slot_in_t'($urandom()));
    send(MODE_UNUSED,  $urandom(), slot_in_t'($urandom()));
    send(MODE_ALLOC,   $urandom(), slot_in_t'($urandom()));
    send(MODE_ALLOC,   $urandom(), slot_in_t'($urandom()));
    send(MODE_ALLOC,   $urandom(), slot_in_t'($urandom()));
    send(MODE_STEP_F,  $urandom(), slot_in_t'($urandom()));
    send(MODE_STEP_B,  $urandom(), slot_in_t'($urandom()));
    send(MODE_TEST_H,  32'd1, slot_in_t'($urandom()));
    send(MODE_PEEK,    $urandom(), slot_in_t'($urandom()));
    send(MODE_RELEASE, 32'd1, slot_in_t'($urandom()));
    send(MODE_RELEASE, 32'd1, slot_in_t'($urandom()));
    send(MODE_TEST_H,  32'd1, slot_in_t'($urandom()));
    send(MODE_RELEASE, 32'd2, slot_in_t'($urandom()));
    send(MODE_RELEASE, 32'd0, slot_in_t'($urandom()));
    send(MODE_STEP_F,  $urandom(), slot_in_t'($urandom()));
    start <= 1'b0;

    // Drain, then forget the directed handles: all slots are free again
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    live_pool.delete();
    held = 0;

    // Fill the pool until allocation fails, back to back
    while (held < SLOTS) random_command(85, 5);
    repeat (3) send(MODE_ALLOC, $urandom(), slot_in_t'($urandom()));
    send(MODE_PEEK, $urandom(), slot_in_t'($urandom()));

    // Mixed traffic: heavy sender idling, none, then moderate idling
    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 16 == 0) quiet = ($urandom_range(3) == 0);
        idle_pct = quiet ? 0 : pct[p];
        random_command(aw[p], rw[p]);
      end
    end
    start <= 1'b0;

    // Wait out the last results
    waited = 0;
    @(posedge clk);
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
